// ----- rtl/core/dirty_rect_dedup_accumulator_assert.svh -----
// assertion macros used by the checker file
`ifndef DIRTY_RECT_DEDUP_ACCUMULATOR_ASSERT_SVH
`define DIRTY_RECT_DEDUP_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define DRDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define DRDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/drda_pkg.sv -----
package drda_pkg;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   localparam logic       OP_INSERT = 1'b0;
   localparam logic       OP_FLUSH  = 1'b1;
   localparam logic [14:0] DIM_MAX  = 15'h7fff;

   typedef struct packed {
      logic        [14:0] h;
      logic        [14:0] w;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } rect_type;

   typedef struct packed {
      logic     holds;    // a contains b
      rect_type bound;    // bounding box of a and b
   } geom_type;

endpackage

// ----- rtl/core/drda_rect_unit.sv -----
module drda_rect_unit (
   input  drda_pkg::rect_type rect_a,
   input  drda_pkg::rect_type rect_b,
   output drda_pkg::geom_type geom
);
   import drda_pkg::*;

   logic signed [16:0] ax1;
   logic signed [16:0] bx1;
   logic signed [16:0] ay1;
   logic signed [16:0] by1;
   logic signed [15:0] x0;
   logic signed [15:0] y0;
   logic signed [16:0] x1;
   logic signed [16:0] y1;
   logic signed [17:0] wd;
   logic signed [17:0] hd;

   // right and bottom edges, exact in 17 bits
   assign ax1 = {rect_a.x[15], rect_a.x} + {2'b00, rect_a.w};
   assign bx1 = {rect_b.x[15], rect_b.x} + {2'b00, rect_b.w};
   assign ay1 = {rect_a.y[15], rect_a.y} + {2'b00, rect_a.h};
   assign by1 = {rect_b.y[15], rect_b.y} + {2'b00, rect_b.h};

   assign x0 = (rect_a.x < rect_b.x) ? rect_a.x : rect_b.x;
   assign y0 = (rect_a.y < rect_b.y) ? rect_a.y : rect_b.y;
   assign x1 = (ax1 > bx1) ? ax1 : bx1;
   assign y1 = (ay1 > by1) ? ay1 : by1;

   assign wd = {x1[16], x1} - {{2{x0[15]}}, x0};
   assign hd = {y1[16], y1} - {{2{y0[15]}}, y0};

   always_comb begin
      geom.holds = (rect_b.x >= rect_a.x) && (rect_b.y >= rect_a.y) &&
                   (bx1 <= ax1) && (by1 <= ay1);
      geom.bound.x = x0;
      geom.bound.y = y0;
      // extent is never negative, so any high bit means saturate
      geom.bound.w = (|wd[17:15]) ? DIM_MAX : wd[14:0];
      geom.bound.h = (|hd[17:15]) ? DIM_MAX : hd[14:0];
   end

endmodule

// ----- rtl/core/dirty_rect_dedup_accumulator.sv -----
// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | tuser: operation; tdata: x, y, w, h
// rsp      | out | rsp_tvalid/rsp_tready  | tdata: x, y, w, h, entry_count; tlast
//
// insert: containment scan, prune pass, place or merge; the single geometry unit
//   visits one table entry per cycle, and a containing entry ends the insert early
// flush: one result beat per held entry (a single all-zero beat for an empty
//   list), each held back while an earlier result beat waits on rsp_tready
// reset (synchronous) empties the list and drops any pending result beat
// req_tready is high only when idle; the result register lets the next item in
//   while the last beat of a flush still waits
module dirty_rect_dedup_accumulator #(
   parameter int MAX_RECTS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [0:0]                       req_tuser,   // operation
   input  logic [drda_pkg::REQ_DATA_W-1:0]  req_tdata,   // rect_x, rect_y, rect_w, rect_h
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic                             rsp_tlast,   // last_entry
   output logic [drda_pkg::RSP_DATA_W-1:0]  rsp_tdata    // out_x, out_y, out_w, out_h,
                                                         // entry_count
);
   import drda_pkg::*;

   localparam int CW = $clog2(MAX_RECTS + 1);
   localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_RECTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_RECTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PRUNE,
      S_PLACE,
      S_FLUSH
   } state_type;

   state_type       state_ff;
   logic [CW-1:0]   idx_ff;
   logic [CW-1:0]   kept_ff;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   flush_n_ff;
   rect_type        new_ff;
   logic            rsp_valid_ff;
   logic            rsp_last_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   rect_type        table_ff [MAX_RECTS];

   logic [CW-1:0]   idx_in;
   logic            idx_last;
   logic [IW-1:0]   rd_idx;
   rect_type        rd_rect;
   rect_type        op_a;
   rect_type        op_b;
   geom_type        geom;
   logic            wr_en;
   logic [IW-1:0]   wr_idx;
   rect_type        wr_rect;
   logic            req_fire;
   logic            out_free;
   logic            rsp_load;
   logic [CW+3:0]   n_ext;
   rect_type        req_rect;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = (state_ff == S_FLUSH) && out_free;
   assign idx_in   = idx_ff + 1'b1;
   assign idx_last = (state_ff == S_FLUSH) ? (idx_in == flush_n_ff) : (idx_in == count_ff);
   assign n_ext    = {4'b0000, flush_n_ff};

   assign req_rect.x = req_tdata[15:0];
   assign req_rect.y = req_tdata[31:16];
   assign req_rect.w = req_tdata[46:32];
   assign req_rect.h = req_tdata[61:47];

   assign rd_idx  = (state_ff == S_PLACE) ? LAST_IDX : idx_ff[IW-1:0];
   assign rd_rect = table_ff[rd_idx];

   // scan asks whether an entry holds the new one, prune the other way round
   always_comb begin
      if (state_ff == S_PRUNE) begin
         op_a = new_ff;
         op_b = rd_rect;
      end else begin
         op_a = rd_rect;
         op_b = new_ff;
      end
   end

   drda_rect_unit u_rect_unit (
      .rect_a (op_a),
      .rect_b (op_b),
      .geom   (geom)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = kept_ff[IW-1:0];
      wr_rect = new_ff;
      unique case (state_ff)
         S_PRUNE: begin
            wr_en   = !geom.holds;
            wr_rect = rd_rect;
         end
         S_PLACE: begin
            wr_en = 1'b1;
            if (kept_ff == FULL_CNT) begin
               wr_idx  = LAST_IDX;
               wr_rect = geom.bound;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_idx] <= wr_rect;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         kept_ff      <= '0;
         count_ff     <= '0;
         flush_n_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               idx_ff  <= '0;
               kept_ff <= '0;
               if (req_fire) begin
                  if (req_tuser[0] == OP_FLUSH) begin
                     flush_n_ff <= count_ff;
                     count_ff   <= '0;
                     state_ff   <= S_FLUSH;
                  end else begin
                     new_ff   <= req_rect;
                     state_ff <= (count_ff == '0) ? S_PLACE : S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               priority if (geom.holds) begin
                  state_ff <= S_IDLE;
               end else if (idx_last) begin
                  idx_ff   <= '0;
                  state_ff <= S_PRUNE;
               end else begin
                  idx_ff <= idx_in;
               end
            end
            S_PRUNE: begin
               if (!geom.holds) begin
                  kept_ff <= kept_ff + 1'b1;
               end
               if (idx_last) begin
                  state_ff <= S_PLACE;
               end else begin
                  idx_ff <= idx_in;
               end
            end
            S_PLACE: begin
               count_ff <= (kept_ff == FULL_CNT) ? FULL_CNT : kept_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            S_FLUSH: begin
               if (out_free) begin
                  if (flush_n_ff == '0) begin
                     rsp_data_ff <= '0;
                     rsp_last_ff <= 1'b1;
                     state_ff    <= S_IDLE;
                  end else begin
                     rsp_data_ff <= {6'b000000, n_ext[3:0], rd_rect.h, rd_rect.w,
                                     rd_rect.y, rd_rect.x};
                     rsp_last_ff <= idx_last;
                     if (idx_last) begin
                        state_ff <= S_IDLE;
                     end else begin
                        idx_ff <= idx_in;
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/drda_checker.sv -----
module drda_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            rsp_tlast,
   input logic [drda_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   `include "dirty_rect_dedup_accumulator_assert.svh"

   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // a stalled result beat keeps its payload
   `DRDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result beat changed while stalled")

   // every accepted item leaves the block busy in the cycle after it is taken
   `DRDA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, !req_tready,
      "ready right after an accepted item")

   // no new item while a flush is still mid-list
   `DRDA_ASSERT_NOW(a_no_req_mid_flush, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready,
      "ready during an unfinished flush")

   // a flush streams without gaps and with one count
   `DRDA_ASSERT_NEXT(a_flush_stream, clock, reset, rsp_beat && !rsp_tlast,
      rsp_tvalid && $stable(rsp_tdata[65:62]), "flush list broken or count changed")

endmodule

bind dirty_rect_dedup_accumulator drda_checker u_drda_checker (.*);
